/* src/tcw_pkg.sv */
// Package: types, codes and constants shared by the text console writer modules.
`timescale 1ns / 1ps

package tcw_pkg;

    // Fixed field widths
    localparam int OP_W   = 3;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_DATA_W = ATTR_W + CHAR_W;

    // Default screen geometry
    localparam int DEF_NUM_COLUMNS = 80;
    localparam int DEF_NUM_ROWS    = 25;

    // Cell and character constants
    localparam logic [CELL_DATA_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [ATTR_W-1:0]      ATTR_RESET   = 8'h07;
    localparam logic [CHAR_W-1:0]      NEWLINE_CODE = 8'h0A;

    // Operation codes of an input item
    localparam logic [OP_W-1:0] OP_CHAR    = 3'd0;
    localparam logic [OP_W-1:0] OP_MOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_SAVE    = 3'd2;
    localparam logic [OP_W-1:0] OP_RESTORE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  target_col;
        logic [ROW_W-1:0]  target_row;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_out_item;

    // Classified command passed from front to back
    typedef enum logic [2:0] {
        CMD_WRITE,
        CMD_NEWLINE,
        CMD_MOVE,
        CMD_SAVE,
        CMD_RESTORE,
        CMD_READ,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_SCROLL,
        ST_FILL
    } t_back_state;

endpackage

/* src/text_console_writer_top.sv */
// Top level of the text console writer: front end, command queue and back end.
//
//  Channel   Direction  Handshake                Payload
//  in        input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (text_attr)
//
// A cell read passes through ST_RDWAIT for the registered store read; the result register
// holds off the next command until it moves. A line feed, or a write in the last column,
// on the bottom row scrolls: the store walk copies each row up one and blanks the bottom row.
// After reset a clearing pass writes blanks to every cell; no item is accepted meanwhile.
// The two-entry queue keeps accepting while the back end stalls, until it is full.
`timescale 1ns / 1ps

module text_console_writer_top import tcw_pkg::*; #(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = DEF_NUM_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ATTR_W-1:0] i_cfg_data
);

    logic w_busy_clear;
    logic w_q_push_valid;
    logic w_q_push_ready;
    t_cmd w_q_push_cmd;
    logic w_q_pop_valid;
    logic w_q_pop;
    t_cmd w_q_pop_cmd;

    // Attribute writes always land at once
    assign o_cfg_ready = 1'b1;

    tcw_front #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_busy_clear (w_busy_clear),
        .i_q_ready    (w_q_push_ready),
        .o_q_valid    (w_q_push_valid),
        .o_q_cmd      (w_q_push_cmd)
    );

    tcw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_q_push_valid),
        .o_push_ready (w_q_push_ready),
        .i_push_cmd   (w_q_push_cmd),
        .o_pop_valid  (w_q_pop_valid),
        .i_pop        (w_q_pop),
        .o_pop_cmd    (w_q_pop_cmd)
    );

    tcw_back #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_pop_valid),
        .i_cmd        (w_q_pop_cmd),
        .o_cmd_pop    (w_q_pop),
        .o_busy_clear (w_busy_clear),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

/* src/tcw_front.sv */
// Front end: accepts input items and classifies them into back-end commands.
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; #(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = DEF_NUM_ROWS
) (
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_busy_clear,
    input  logic     i_q_ready,
    output logic     o_q_valid,
    output t_cmd     o_q_cmd
);

    logic w_in_range;

    // Check target against the screen geometry
    assign w_in_range = ({1'b0, i_in_data.target_col} < (COL_W + 1)'(NUM_COLUMNS)) &&
                        ({1'b0, i_in_data.target_row} < (ROW_W + 1)'(NUM_ROWS));

    // Hold off items while the screen clear runs
    assign o_in_ready = i_q_ready && !i_busy_clear;
    assign o_q_valid  = i_in_valid && !i_busy_clear;

    // Classify the item; drop out-of-range moves and reads to no-ops
    always_comb begin
        o_q_cmd.ch  = i_in_data.char_code;
        o_q_cmd.col = i_in_data.target_col;
        o_q_cmd.row = i_in_data.target_row;
        unique case (i_in_data.operation)
            OP_CHAR: begin
                o_q_cmd.kind = (i_in_data.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_WRITE;
            end
            OP_MOVE: begin
                o_q_cmd.kind = w_in_range ? CMD_MOVE : CMD_NOP;
            end
            OP_SAVE: begin
                o_q_cmd.kind = CMD_SAVE;
            end
            OP_RESTORE: begin
                o_q_cmd.kind = CMD_RESTORE;
            end
            OP_READ: begin
                o_q_cmd.kind = w_in_range ? CMD_READ : CMD_NOP;
            end
            default: begin
                o_q_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

/* src/tcw_queue.sv */
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps

module tcw_queue import tcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_cmd o_pop_cmd
);

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_entry[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    // Store pushed command
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/tcw_back.sv */
// Back end: cursor state, screen store, scroll and clear sequencer, result register.
`timescale 1ns / 1ps

module tcw_back import tcw_pkg::*; #(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = DEF_NUM_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_busy_clear,
    input  logic        i_cfg_valid,
    input  logic [ATTR_W-1:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int CELLS  = NUM_COLUMNS * NUM_ROWS;
    localparam int CELL_W = $clog2(CELLS);
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] ROW_SPAN  = CELL_W'(NUM_COLUMNS);
    localparam logic [CELL_W-1:0] FILL_BASE = CELL_W'(CELLS - NUM_COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(NUM_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(NUM_ROWS - 1);

    logic [CELL_DATA_W-1:0] r_mem [CELLS];
    logic [CELL_DATA_W-1:0] r_rdata;

    t_back_state       r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_scol, n_scol;
    logic [ROW_W-1:0]  r_srow, n_srow;
    logic [CELL_W-1:0] r_addr, n_addr;
    logic [CELL_W-1:0] r_src, n_src;
    logic              r_pend, n_pend;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [ATTR_W-1:0] r_text_attr;

    logic                   w_we;
    logic [CELL_W-1:0]      w_waddr;
    logic [CELL_DATA_W-1:0] w_wdata;
    logic [CELL_W-1:0]      w_raddr;
    logic                   w_line;
    logic [CELL_W-1:0]      w_cur_addr;
    logic [CELL_W-1:0]      w_tgt_addr;

    assign w_cur_addr = CELL_W'(r_row) * ROW_SPAN + CELL_W'(r_col);
    assign w_tgt_addr = CELL_W'(i_cmd.row) * ROW_SPAN + CELL_W'(i_cmd.col);

    assign o_busy_clear = (r_state == ST_CLEAR);
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    // Screen store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Take attribute writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_text_attr <= i_cfg_data;
        end
    end

    // State and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_scol      <= '0;
            r_srow      <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_scol      <= n_scol;
            r_srow      <= n_srow;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_src <= n_src;
    end

    // Next state, store control and result
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_scol      = r_scol;
        n_srow      = r_srow;
        n_addr      = r_addr;
        n_src       = r_src;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = BLANK_CELL;
        w_raddr     = r_addr;
        w_line      = 1'b0;
        o_cmd_pop   = 1'b0;

        // Drop the result once transferred
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
                if (r_addr == LAST_CELL) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + CELL_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_WRITE: begin
                            w_we    = 1'b1;
                            w_waddr = w_cur_addr;
                            w_wdata = {r_text_attr, i_cmd.ch};
                            if (r_col == LAST_COL) begin
                                w_line = 1'b1;
                            end else begin
                                n_col = r_col + COL_W'(1);
                            end
                        end
                        CMD_NEWLINE: begin
                            w_line = 1'b1;
                        end
                        CMD_MOVE: begin
                            n_col = i_cmd.col;
                            n_row = i_cmd.row;
                        end
                        CMD_SAVE: begin
                            n_scol = r_col;
                            n_srow = r_row;
                        end
                        CMD_RESTORE: begin
                            n_col = r_scol;
                            n_row = r_srow;
                        end
                        CMD_READ: begin
                            w_raddr = w_tgt_addr;
                            n_state = ST_RDWAIT;
                        end
                        default: begin
                        end
                    endcase
                    // Go to the next line, scrolling from the bottom row
                    if (w_line) begin
                        n_col = '0;
                        if (r_row == LAST_ROW) begin
                            n_state = ST_SCROLL;
                            n_addr  = ROW_SPAN;
                            n_pend  = 1'b0;
                        end else begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end
                    if (n_state == ST_IDLE) begin
                        n_out = '{cell_char: '0, cell_attr: '0,
                                  cursor_col: n_col, cursor_row: n_row};
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_RDWAIT: begin
                n_out = '{cell_char: r_rdata[CHAR_W-1:0],
                          cell_attr: r_rdata[CELL_DATA_W-1:CHAR_W],
                          cursor_col: r_col, cursor_row: r_row};
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_SCROLL: begin
                // Read one row ahead, write the previous read one row up
                w_raddr = r_addr;
                n_src   = r_addr;
                n_pend  = 1'b1;
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_src - ROW_SPAN;
                    w_wdata = r_rdata;
                end
                if (r_addr == LAST_CELL) begin
                    n_addr  = FILL_BASE;
                    n_state = ST_FILL;
                end else begin
                    n_addr = r_addr + CELL_W'(1);
                end
            end
            ST_FILL: begin
                if (r_pend) begin
                    // Finish the last copy first
                    w_we    = 1'b1;
                    w_waddr = r_src - ROW_SPAN;
                    w_wdata = r_rdata;
                    n_pend  = 1'b0;
                end else begin
                    w_we = 1'b1;
                    if (r_addr == LAST_CELL) begin
                        n_addr      = '0;
                        n_state     = ST_IDLE;
                        n_out       = '{cell_char: '0, cell_attr: '0,
                                        cursor_col: r_col, cursor_row: r_row};
                        n_out_valid = 1'b1;
                    end else begin
                        n_addr = r_addr + CELL_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
